[hw/rtl/two_material_face_blend_select_assert.svh]
// Assertion macros for the face blend select block.
`ifndef TWO_MATERIAL_FACE_BLEND_SELECT_ASSERT_SVH
`define TWO_MATERIAL_FACE_BLEND_SELECT_ASSERT_SVH

// Implication in the same cycle.
`define TMFBS_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error(msg);

// Implication a fixed number of cycles later.
`define TMFBS_ASSERT_DELAY(label, clk, rst_n, a, n, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
		else $error(msg);

`endif

[hw/rtl/tmfbs_pkg.sv]
// Types and constants of the face blend select block.
`default_nettype none

package tmfbs_pkg;

	localparam int unsigned ENTRY_COUNT = 6;
	localparam logic [7:0] FULL_WEIGHT = 8'd255;

	typedef struct packed {
		logic [7:0] vert_a_first_index;
		logic [7:0] vert_a_second_index;
		logic [7:0] vert_a_blend;
		logic [7:0] vert_b_first_index;
		logic [7:0] vert_b_second_index;
		logic [7:0] vert_b_blend;
		logic [7:0] vert_c_first_index;
		logic [7:0] vert_c_second_index;
		logic [7:0] vert_c_blend;
	} face_item_t;

	typedef struct packed {
		logic [7:0] face_low_index;
		logic [7:0] face_high_index;
		logic [7:0] face_blend;
	} face_result_t;

	// Running state of the best / second best scan.
	typedef struct packed {
		logic [7:0] best_id;
		logic [7:0] best_s;
		logic       best_ok;
		logic [7:0] second_id;
		logic [7:0] second_s;
		logic       second_ok;
	} scan_t;

endpackage

`default_nettype wire

[hw/rtl/two_material_face_blend_select.sv]
// Face material pair and blend selection from three two-material vertices.
//
// Usage: drive item and raise start for one cycle per face; a transfer takes
// place at each rising edge with start high and busy low. busy is never
// raised, so a face may be offered in every cycle.
// Each result appears on result for exactly one cycle with done high, after
// its input transfer has passed stages 1 to 5, the last of which loads the
// output register. Results leave in input order.
// Throughput: one face per cycle, set by the five-stage pipeline:
//   s1 entry build and index compare matrix, s2 first-occurrence flags and
//   per-index peak strength, s3 scan of entries 0..2, s4 scan of entries
//   3..5, s5 blend arithmetic, ordering of the pair and output register.
// The receiver cannot hold results off; a result not taken is dropped.
// Reset (arst_n low, asynchronous) clears all stage valid bits, so nothing
// in flight survives and done stays low until a new face has gone through.
// No state is kept between faces.
`default_nettype none

module two_material_face_blend_select (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	output logic                   busy,
	input  tmfbs_pkg::face_item_t  item,
	output logic                   done,
	output tmfbs_pkg::face_result_t result
);

	import tmfbs_pkg::*;

	`include "two_material_face_blend_select_assert.svh"

	localparam int unsigned HALF = ENTRY_COUNT / 2;

	function automatic scan_t scan_step(input scan_t st, input logic live,
			input logic [7:0] id, input logic [7:0] s);
		scan_t nx;
		nx = st;
		if (live) begin
			if (!st.best_ok || s >= st.best_s) begin
				nx.second_id = st.best_id;
				nx.second_s  = st.best_s;
				nx.second_ok = st.best_ok;
				nx.best_id   = id;
				nx.best_s    = s;
				nx.best_ok   = 1'b1;
			end else if (!st.second_ok || s > st.second_s) begin
				nx.second_id = id;
				nx.second_s  = s;
				nx.second_ok = 1'b1;
			end
		end
		return nx;
	endfunction

	logic accept;

	// stage 1
	logic                            valid_s1;
	logic [ENTRY_COUNT-1:0][7:0]     id_s1;
	logic [ENTRY_COUNT-1:0][7:0]     str_s1;
	logic [ENTRY_COUNT-1:0][ENTRY_COUNT-1:0] eq_s1;
	logic [ENTRY_COUNT-1:0][7:0]     id_in;
	logic [ENTRY_COUNT-1:0][7:0]     str_in;

	// stage 2
	logic                            valid_s2;
	logic [ENTRY_COUNT-1:0][7:0]     id_s2;
	logic [ENTRY_COUNT-1:0][7:0]     str_s2;
	logic [ENTRY_COUNT-1:0]          first_s2;
	logic [ENTRY_COUNT-1:0][7:0]     peak;
	logic [ENTRY_COUNT-1:0]          first_c;

	// stages 3 and 4
	logic                            valid_s3;
	logic [ENTRY_COUNT-1:0][7:0]     id_s3;
	logic [ENTRY_COUNT-1:0][7:0]     str_s3;
	logic [ENTRY_COUNT-1:0]          first_s3;
	scan_t                           scan_s3;
	scan_t                           scan_lo;
	logic                            valid_s4;
	scan_t                           scan_s4;
	scan_t                           scan_hi;

	// stage 5
	logic                            valid_s5;
	face_result_t                    result_s5;
	face_result_t                    res_c;
	logic [7:0]                      sec_id;
	logic [7:0]                      sec_s;
	logic [8:0]                      sum;
	logic [7:0]                      blend;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// entry order: A first, A second, B first, B second, C first, C second
	always_comb begin
		id_in[0]  = item.vert_a_first_index;
		str_in[0] = FULL_WEIGHT - item.vert_a_blend;
		id_in[1]  = item.vert_a_second_index;
		str_in[1] = item.vert_a_blend;
		id_in[2]  = item.vert_b_first_index;
		str_in[2] = FULL_WEIGHT - item.vert_b_blend;
		id_in[3]  = item.vert_b_second_index;
		str_in[3] = item.vert_b_blend;
		id_in[4]  = item.vert_c_first_index;
		str_in[4] = FULL_WEIGHT - item.vert_c_blend;
		id_in[5]  = item.vert_c_second_index;
		str_in[5] = item.vert_c_blend;
	end

	always_ff @(posedge clk) begin
		id_s1  <= id_in;
		str_s1 <= str_in;
		for (int j = 0; j < ENTRY_COUNT; j++) begin
			for (int k = 0; k < ENTRY_COUNT; k++) begin
				eq_s1[j][k] <= (id_in[j] == id_in[k]);
			end
		end
	end

	// peak strength over all entries sharing the index; first-occurrence flag
	always_comb begin
		for (int j = 0; j < ENTRY_COUNT; j++) begin
			peak[j]    = 8'd0;
			first_c[j] = 1'b1;
			for (int k = 0; k < ENTRY_COUNT; k++) begin
				if (eq_s1[j][k] && str_s1[k] > peak[j]) begin
					peak[j] = str_s1[k];
				end
				if (k < j && eq_s1[j][k]) begin
					first_c[j] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		id_s2    <= id_s1;
		str_s2   <= peak;
		first_s2 <= first_c;
	end

	always_comb begin
		scan_lo = '0;
		for (int k = 0; k < HALF; k++) begin
			scan_lo = scan_step(scan_lo, first_s2[k], id_s2[k], str_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		id_s3    <= id_s2;
		str_s3   <= str_s2;
		first_s3 <= first_s2;
		scan_s3  <= scan_lo;
	end

	always_comb begin
		scan_hi = scan_s3;
		for (int k = HALF; k < ENTRY_COUNT; k++) begin
			scan_hi = scan_step(scan_hi, first_s3[k], id_s3[k], str_s3[k]);
		end
	end

	always_ff @(posedge clk) begin
		scan_s4 <= scan_hi;
	end

	// lone index pairs with itself at zero strength
	always_comb begin
		sec_id = scan_s4.second_ok ? scan_s4.second_id : scan_s4.best_id;
		sec_s  = scan_s4.second_ok ? scan_s4.second_s : 8'd0;
		sum    = {1'b0, FULL_WEIGHT - scan_s4.best_s} + {1'b0, sec_s};
		blend  = sum[8:1];
		if (scan_s4.best_id > sec_id) begin
			res_c.face_low_index  = sec_id;
			res_c.face_high_index = scan_s4.best_id;
			res_c.face_blend      = FULL_WEIGHT - blend;
		end else begin
			res_c.face_low_index  = scan_s4.best_id;
			res_c.face_high_index = sec_id;
			res_c.face_blend      = blend;
		end
	end

	always_ff @(posedge clk) begin
		result_s5 <= res_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	assign done   = valid_s5;
	assign result = result_s5;

	`TMFBS_ASSERT_DELAY(a_latency, clk, arst_n, accept, 5, done, "transfer without result")
	`TMFBS_ASSERT_IMPL(a_order, clk, arst_n, done,
		result.face_low_index <= result.face_high_index, "index pair out of order")
	`TMFBS_ASSERT_IMPL(a_single, clk, arst_n,
		done && result.face_low_index == result.face_high_index,
		!result.face_blend[7], "single index blend above half")
	`TMFBS_ASSERT_IMPL(a_first, clk, arst_n, valid_s2, first_s2[0],
		"leading entry not marked first")

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking bench for the face material pair and blend select block.
`timescale 1ns / 1ps

module tb_top;
	import tmfbs_pkg::*;

	localparam int unsigned FACE_COUNT  = 1700;
	localparam int unsigned QUIET_TAIL  = 300;
	localparam int unsigned DRAIN_EDGES = 8;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// Expected face pairs in transfer order, with the pair selection worked out per face.
	class face_pair_book;
		face_result_t expected_pairs [$];
		int unsigned  fail_count;

		function new();
			fail_count = 0;
		endfunction

		function int unsigned pending();
			return expected_pairs.size();
		endfunction

		task report_mismatch(input string what);
			$display("MISMATCH: %s", what);
			fail_count++;
		endtask

		function face_result_t predict_face_pair(input face_item_t f);
			logic [7:0]   ent_id [6];
			logic [7:0]   ent_s [6];
			logic [7:0]   ids [6];
			logic [7:0]   strs [6];
			logic [7:0]   best_id, best_s, second_id, second_s, blend;
			logic [8:0]   sum;
			logic         best_ok, second_ok, found;
			int unsigned  n, e, k;
			face_result_t r;
			ent_id[0] = f.vert_a_first_index;  ent_s[0] = FULL_WEIGHT - f.vert_a_blend;
			ent_id[1] = f.vert_a_second_index; ent_s[1] = f.vert_a_blend;
			ent_id[2] = f.vert_b_first_index;  ent_s[2] = FULL_WEIGHT - f.vert_b_blend;
			ent_id[3] = f.vert_b_second_index; ent_s[3] = f.vert_b_blend;
			ent_id[4] = f.vert_c_first_index;  ent_s[4] = FULL_WEIGHT - f.vert_c_blend;
			ent_id[5] = f.vert_c_second_index; ent_s[5] = f.vert_c_blend;
			n = 0;
			// distinct indices in order of first appearance, each at its peak strength
			for (e = 0; e < ENTRY_COUNT; e++) begin
				found = 1'b0;
				for (k = 0; k < n; k++) begin
					if (ids[k] == ent_id[e]) begin
						found = 1'b1;
						if (ent_s[e] > strs[k])
							strs[k] = ent_s[e];
					end
				end
				if (!found) begin
					ids[n]  = ent_id[e];
					strs[n] = ent_s[e];
					n++;
				end
			end
			best_ok = 1'b0; second_ok = 1'b0;
			best_id = '0; best_s = '0; second_id = '0; second_s = '0;
			for (k = 0; k < n; k++) begin
				if (!best_ok || strs[k] >= best_s) begin
					second_id = best_id;
					second_s  = best_s;
					second_ok = best_ok;
					best_id   = ids[k];
					best_s    = strs[k];
					best_ok   = 1'b1;
				end else if (!second_ok || strs[k] > second_s) begin
					second_id = ids[k];
					second_s  = strs[k];
					second_ok = 1'b1;
				end
			end
			if (!second_ok) begin
				second_id = best_id;
				second_s  = '0;
			end
			sum   = {1'b0, FULL_WEIGHT - best_s} + {1'b0, second_s};
			blend = sum[8:1];
			if (best_id > second_id) begin
				r.face_low_index  = second_id;
				r.face_high_index = best_id;
				r.face_blend      = FULL_WEIGHT - blend;
			end else begin
				r.face_low_index  = best_id;
				r.face_high_index = second_id;
				r.face_blend      = blend;
			end
			return r;
		endfunction

		function void note_face(input face_item_t f);
			expected_pairs.push_back(predict_face_pair(f));
		endfunction

		task check_result(input face_result_t got);
			face_result_t want;
			if (expected_pairs.size() == 0) begin
				report_mismatch($sformatf("unexpected result %0d/%0d/%0d",
					got.face_low_index, got.face_high_index, got.face_blend));
			end else begin
				want = expected_pairs.pop_front();
				if (got.face_low_index !== want.face_low_index)
					report_mismatch($sformatf("face_low_index got %0d want %0d",
						got.face_low_index, want.face_low_index));
				if (got.face_high_index !== want.face_high_index)
					report_mismatch($sformatf("face_high_index got %0d want %0d",
						got.face_high_index, want.face_high_index));
				if (got.face_blend !== want.face_blend)
					report_mismatch($sformatf("face_blend got %0d want %0d",
						got.face_blend, want.face_blend));
			end
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         start;
	logic         busy;
	face_item_t   item;
	logic         done;
	face_result_t result;

	face_pair_book face_book;
	int unsigned   cycle_count;

	two_material_face_blend_select u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial cycle_count = 0;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// outputs and inputs are sampled as they stood before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				face_book.check_result(result);
			if (start && !busy)
				face_book.note_face(item);
		end
	end

	function automatic face_item_t make_face(
		input logic [7:0] a1, a2, ab, b1, b2, bb, c1, c2, cb);
		return {a1, a2, ab, b1, b2, bb, c1, c2, cb};
	endfunction

	function automatic logic [7:0] pick_blend();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'd127;
			3:       return 8'd128;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly few distinct indices so that merges, ties and single-index faces occur often.
	function automatic face_item_t random_face();
		logic [7:0]  pool [4];
		logic [7:0]  fld [9];
		int unsigned pool_size, k;
		pool_size = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4);
		for (k = 0; k < 4; k++) begin
			case ($urandom_range(0, 5))
				0:       pool[k] = 8'd0;
				1:       pool[k] = 8'd255;
				default: pool[k] = 8'($urandom_range(0, 255));
			endcase
		end
		for (k = 0; k < 9; k++) begin
			if (k % 3 == 2)
				fld[k] = (pool_size == 0) ? 8'($urandom_range(0, 255)) : pick_blend();
			else if (pool_size == 0)
				fld[k] = 8'($urandom_range(0, 255));
			else
				fld[k] = pool[$urandom_range(0, pool_size - 1)];
		end
		return {fld[0], fld[1], fld[2], fld[3], fld[4], fld[5], fld[6], fld[7], fld[8]};
	endfunction

	// Called just after a rising edge; returns at the edge where the transfer happens.
	task automatic send_face(input face_item_t f);
		start <= 1'b1;
		item  <= f;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic idle_sender(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_all_results();
		idle_sender(1);
		while (face_book.pending() != 0)
			@(posedge clk);
	endtask

	task automatic offer_face(input face_item_t f, input int unsigned seq);
		if (seq < FACE_COUNT - QUIET_TAIL && (seq / 150) % 2 == 0
				&& $urandom_range(0, 2) == 0)
			idle_sender($urandom_range(1, 15));
		send_face(f);
	endtask

	initial begin
		face_item_t  directed [$];
		int unsigned seq;
		face_book = new();
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single index everywhere, extremes of index and blend
		directed.push_back(make_face(0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_face(255, 255, 255, 255, 255, 255, 255, 255, 255));
		directed.push_back(make_face(90, 90, 128, 90, 90, 128, 90, 90, 128));
		directed.push_back(make_face(90, 90, 127, 90, 90, 127, 90, 90, 127));
		// descending pair is swapped and the blend mirrored; ascending one is not
		directed.push_back(make_face(200, 10, 0, 200, 10, 0, 200, 10, 0));
		directed.push_back(make_face(10, 200, 0, 10, 200, 0, 10, 200, 0));
		// equal and near-equal strengths: on a tie the later index wins
		directed.push_back(make_face(5, 9, 128, 9, 5, 127, 5, 9, 128));
		directed.push_back(make_face(9, 5, 128, 5, 9, 128, 9, 5, 128));
		directed.push_back(make_face(255, 0, 255, 255, 0, 255, 255, 0, 255));
		directed.push_back(make_face(0, 255, 0, 0, 255, 0, 0, 255, 0));
		directed.push_back(make_face(0, 255, 128, 0, 255, 128, 0, 255, 128));
		// six distinct indices
		directed.push_back(make_face(1, 2, 30, 3, 4, 60, 5, 6, 90));
		directed.push_back(make_face(0, 255, 255, 128, 127, 1, 64, 192, 200));
		directed.push_back(make_face(250, 240, 1, 230, 220, 254, 210, 200, 100));
		// same index on both sides of a vertex
		directed.push_back(make_face(77, 77, 100, 77, 77, 50, 33, 33, 0));
		// later entry beats the second but not the best
		directed.push_back(make_face(40, 50, 10, 60, 70, 200, 80, 90, 150));
		directed.push_back(make_face(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
			8'hAA, 8'h55, 8'h00));
		directed.push_back(make_face(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA,
			8'h55, 8'hAA, 8'hFF));
		directed.push_back(make_face(3, 4, 1, 5, 6, 1, 7, 8, 254));
		directed.push_back(make_face(12, 13, 254, 12, 14, 1, 13, 14, 128));

		seq = 0;
		foreach (directed[i]) begin
			offer_face(directed[i], seq);
			seq++;
		end
		while (seq < FACE_COUNT) begin
			if (seq == FACE_COUNT / 2)
				wait_all_results();
			offer_face(random_face(), seq);
			seq++;
		end

		wait_all_results();
		repeat (DRAIN_EDGES) @(posedge clk);
		if (face_book.fail_count == 0 && face_book.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
